// File: rtl/jbdf_pkg.sv
// Shared constants, widths and the fraction table of the joint bilateral depth filter.
package jbdf_pkg;

  localparam int MAX_WIDTH   = 512;
  localparam int MAX_HEIGHT  = 512;
  localparam int MAX_RADIUS  = 8;

  localparam int X_W         = $clog2(MAX_WIDTH);
  localparam int Y_W         = $clog2(MAX_HEIGHT);
  localparam int ADDR_W      = X_W + Y_W;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;

  localparam int DIM_W       = 10;
  localparam int RAD_W       = 4;
  localparam int COEF_W      = 16;
  localparam int CW_W        = 17;
  localparam int CFG_W       = 17;
  localparam int CIDX_W      = 3;

  localparam logic CMD_STORE  = 1'b0;
  localparam logic CMD_FILTER = 1'b1;

  typedef enum logic [CIDX_W-1:0] {
    REG_WIDTH, REG_HEIGHT, REG_RADIUS, REG_SPATIAL,
    REG_RANGE, REG_RED, REG_GREEN, REG_BLUE
  } reg_idx_t;

  localparam int LUMA_W      = 16;
  localparam int DEPTH_W     = 16;
  localparam int WT_W        = 17;
  localparam int D2_W        = 2 * RAD_W + 1;
  localparam int WIN_MAX     = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
  localparam int WSUM_W      = WT_W + $clog2(WIN_MAX);
  localparam int DSUM_W      = WT_W + DEPTH_W + $clog2(WIN_MAX);
  localparam int NUM_W       = DSUM_W + 1;

  // Luminance: sum of three 8 x 17 products plus rounding, divided by 255.
  localparam int LSUM_W      = 27;
  localparam int LQ_W        = 20;
  localparam int LPROD_W     = LSUM_W + 16;
  localparam logic [15:0] INV255 = 16'd32896;
  localparam int INV255_SH   = 23;

  typedef logic [WT_W-1:0] frac_tab_t [256];

  function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] res;
    logic [63:0] bv;
    n   = n_in;
    res = 64'd0;
    bv  = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (n >= res + bv) begin
        n   = n - (res + bv);
        res = (res >> 1) + bv;
      end else begin
        res = res >> 1;
      end
      bv = bv >> 2;
    end
    return res;
  endfunction

  // Entry f is 2^-(f/256) in Q1.16, built from chained square roots of one half.
  function automatic frac_tab_t build_frac_table();
    frac_tab_t   tab;
    logic [63:0] roots [8];
    logic [63:0] p;
    roots[7] = isqrt64(64'h8000_0000_0000_0000);
    for (int j = 7; j > 0; j--) begin
      roots[j-1] = isqrt64(roots[j] << 32);
    end
    for (int f = 0; f < 256; f++) begin
      p = 64'h1_0000_0000;
      for (int j = 0; j < 8; j++) begin
        if (((f >> j) & 1) == 1) begin
          p = (p * roots[j]) >> 32;
        end
      end
      tab[f] = WT_W'((p + 64'd32768) >> 16);
    end
    return tab;
  endfunction

  localparam frac_tab_t FRAC_TABLE = build_frac_table();

endpackage

// File: rtl/jbdf_div.sv
// Restoring divider, one quotient bit per cycle, for the weighted depth average.
module jbdf_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [jbdf_pkg::NUM_W-1:0]        numer,
  input  logic [jbdf_pkg::WSUM_W-1:0]       denom,
  output logic                              done,
  output logic [jbdf_pkg::NUM_W-1:0]        quot
);

  localparam int CNT_W = $clog2(jbdf_pkg::NUM_W + 1);

  logic                            running;
  logic [CNT_W-1:0]                cnt;
  logic [jbdf_pkg::WSUM_W-1:0]     rem;
  logic [jbdf_pkg::WSUM_W-1:0]     dvs;
  logic [jbdf_pkg::WSUM_W:0]       rem_sh;
  logic                            qbit;

  assign rem_sh = {rem, quot[jbdf_pkg::NUM_W-1]};
  assign qbit   = (rem_sh >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CNT_W'(jbdf_pkg::NUM_W);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= numer;
      rem  <= '0;
      dvs  <= denom;
    end else if (running) begin
      quot <= {quot[jbdf_pkg::NUM_W-2:0], qbit};
      if (qbit) begin
        rem <= jbdf_pkg::WSUM_W'(rem_sh - {1'b0, dvs});
      end else begin
        rem <= rem_sh[jbdf_pkg::WSUM_W-1:0];
      end
    end
  end

endmodule

// File: rtl/joint_bilateral_depth_filter.sv
// Top level of the joint bilateral depth filter: frame store, window walk and weighting pipeline.
//
// Usage: a request is taken on a clock edge where start is high and busy is low.
// command 0 stores the pixel's depth and its luminance (formed from red, green and
// blue) at (pixel_x, pixel_y); it gives no result and keeps busy high while the
// luminance is weighted, divided by 255, corrected and written.
// command 1 filters the pixel at (pixel_x, pixel_y) over a (2R+1)^2 window read from
// the frame store one neighbour per cycle through a single-port memory. The result
// appears on refined_depth, used_centre, out_x and out_y for one cycle with
// result_valid high, after the centre read, the window walk, the draining of the
// weighting pipeline and the bit-serial divide (the divide is skipped when the
// weight sum is zero, and the centre depth is returned with used_centre high).
// Requests whose coordinates lie outside the active frame are dropped at once.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is always
// ready; write it only while busy is low. The receiver cannot stall results.
// Reset loads the register defaults and leaves the frame store contents undefined:
// pixels must be stored before they are read.
module joint_bilateral_depth_filter (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              command,
  input  logic [8:0]                        pixel_x,
  input  logic [8:0]                        pixel_y,
  input  logic [7:0]                        red,
  input  logic [7:0]                        green,
  input  logic [7:0]                        blue,
  input  logic [15:0]                       raw_depth,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [jbdf_pkg::CIDX_W-1:0]       cfg_index,
  input  logic [jbdf_pkg::CFG_W-1:0]        cfg_data,
  output logic                              result_valid,
  output logic [15:0]                       refined_depth,
  output logic                              used_centre,
  output logic [8:0]                        out_x,
  output logic [8:0]                        out_y
);

  typedef enum logic [3:0] {
    S_IDLE, S_LUMA_MUL, S_LUMA_EST, S_LUMA_FIX,
    S_CENTRE, S_CAPTURE, S_WINDOW, S_DRAIN, S_DIVIDE
  } state_t;

  localparam int XS_W = jbdf_pkg::X_W + 2;
  localparam int YS_W = jbdf_pkg::Y_W + 2;

  // Configuration registers.
  logic [jbdf_pkg::DIM_W-1:0]  frame_width, frame_height;
  logic [jbdf_pkg::RAD_W-1:0]  window_radius;
  logic [jbdf_pkg::COEF_W-1:0] spatial_coeff, range_coeff;
  logic [jbdf_pkg::CW_W-1:0]   red_weight, green_weight, blue_weight;

  logic [jbdf_pkg::DIM_W-1:0]  w_eff, h_eff;
  logic [jbdf_pkg::RAD_W-1:0]  r_eff;

  state_t                      state;
  logic [jbdf_pkg::X_W-1:0]    cx;
  logic [jbdf_pkg::Y_W-1:0]    cy;
  logic [7:0]                  cr, cg, cb;
  logic [jbdf_pkg::DEPTH_W-1:0] cdepth_in;
  logic [jbdf_pkg::LSUM_W-1:0] lsum;
  logic [jbdf_pkg::LQ_W-1:0]   lq;
  logic [jbdf_pkg::LSUM_W-1:0] lrem;
  logic [jbdf_pkg::LUMA_W-1:0] luma_sat;

  logic signed [jbdf_pkg::RAD_W:0] dx, dy, r_pos, r_neg;
  logic signed [XS_W-1:0]      nx_s, wm1_s;
  logic signed [YS_W-1:0]      ny_s, hm1_s;
  logic [jbdf_pkg::X_W-1:0]    nx;
  logic [jbdf_pkg::Y_W-1:0]    ny;
  logic [jbdf_pkg::RAD_W-1:0]  adx, ady;

  logic                        accept, out_of_frame;

  // Frame store: luminance in the upper half, depth in the lower half.
  logic [jbdf_pkg::LUMA_W+jbdf_pkg::DEPTH_W-1:0] mem [jbdf_pkg::STORE_DEPTH];
  logic [jbdf_pkg::LUMA_W+jbdf_pkg::DEPTH_W-1:0] mem_rdata;
  logic [jbdf_pkg::ADDR_W-1:0] mem_addr;
  logic                        mem_we;

  logic [jbdf_pkg::LUMA_W-1:0]  c_luma;
  logic [jbdf_pkg::DEPTH_W-1:0] c_depth;

  // Weighting pipeline.
  logic                        v1, v2, v3, v4, v5;
  logic [jbdf_pkg::D2_W-1:0]   p1_d2, p2_d2;
  logic [jbdf_pkg::LUMA_W-1:0] dl, p2_dl2;
  logic [jbdf_pkg::DEPTH_W-1:0] p2_depth, p3_depth, p4_depth;
  logic [2*jbdf_pkg::LUMA_W-1:0] dl_sq;
  logic [32:0]                 e_full;
  logic [15:0]                 p3_e;
  logic [jbdf_pkg::WT_W-1:0]   wt_next, p4_wt, p5_wt;
  logic [jbdf_pkg::WT_W+jbdf_pkg::DEPTH_W-1:0] p5_prod;
  logic [jbdf_pkg::WSUM_W-1:0] wsum;
  logic [jbdf_pkg::DSUM_W-1:0] dsum;
  logic                        pipe_busy;

  logic                        div_start, div_done;
  logic [jbdf_pkg::NUM_W-1:0]  div_numer, div_quot;

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;

  assign w_eff = (frame_width == '0) ? jbdf_pkg::DIM_W'(1) :
                 (frame_width > jbdf_pkg::DIM_W'(jbdf_pkg::MAX_WIDTH)) ?
                 jbdf_pkg::DIM_W'(jbdf_pkg::MAX_WIDTH) : frame_width;
  assign h_eff = (frame_height == '0) ? jbdf_pkg::DIM_W'(1) :
                 (frame_height > jbdf_pkg::DIM_W'(jbdf_pkg::MAX_HEIGHT)) ?
                 jbdf_pkg::DIM_W'(jbdf_pkg::MAX_HEIGHT) : frame_height;
  assign r_eff = (window_radius == '0) ? jbdf_pkg::RAD_W'(1) :
                 (window_radius > jbdf_pkg::RAD_W'(jbdf_pkg::MAX_RADIUS)) ?
                 jbdf_pkg::RAD_W'(jbdf_pkg::MAX_RADIUS) : window_radius;
  assign r_pos = $signed({1'b0, r_eff});
  assign r_neg = -r_pos;

  assign out_of_frame = ({1'b0, pixel_x} >= w_eff) || ({1'b0, pixel_y} >= h_eff);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= jbdf_pkg::DIM_W'(512);
      frame_height  <= jbdf_pkg::DIM_W'(512);
      window_radius <= jbdf_pkg::RAD_W'(2);
      spatial_coeff <= jbdf_pkg::COEF_W'(128);
      range_coeff   <= jbdf_pkg::COEF_W'(256);
      red_weight    <= jbdf_pkg::CW_W'(13933);
      green_weight  <= jbdf_pkg::CW_W'(46871);
      blue_weight   <= jbdf_pkg::CW_W'(4732);
    end else if (cfg_valid && cfg_ready) begin
      unique case (jbdf_pkg::reg_idx_t'(cfg_index))
        jbdf_pkg::REG_WIDTH:   frame_width   <= cfg_data[jbdf_pkg::DIM_W-1:0];
        jbdf_pkg::REG_HEIGHT:  frame_height  <= cfg_data[jbdf_pkg::DIM_W-1:0];
        jbdf_pkg::REG_RADIUS:  window_radius <= cfg_data[jbdf_pkg::RAD_W-1:0];
        jbdf_pkg::REG_SPATIAL: spatial_coeff <= cfg_data[jbdf_pkg::COEF_W-1:0];
        jbdf_pkg::REG_RANGE:   range_coeff   <= cfg_data[jbdf_pkg::COEF_W-1:0];
        jbdf_pkg::REG_RED:     red_weight    <= cfg_data;
        jbdf_pkg::REG_GREEN:   green_weight  <= cfg_data;
        jbdf_pkg::REG_BLUE:    blue_weight   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Luminance correction: the reciprocal estimate may sit a few counts low.
  assign lrem = jbdf_pkg::LSUM_W'(lsum - ((jbdf_pkg::LSUM_W'(lq) << 8) - jbdf_pkg::LSUM_W'(lq)));
  assign luma_sat = (lq > jbdf_pkg::LQ_W'(16'hFFFF)) ? 16'hFFFF : lq[jbdf_pkg::LUMA_W-1:0];

  // Neighbour coordinates, clamped to the frame edge.
  assign nx_s  = $signed({2'b00, cx}) + XS_W'(dx);
  assign ny_s  = $signed({2'b00, cy}) + YS_W'(dy);
  assign wm1_s = $signed(XS_W'(w_eff - 1'b1));
  assign hm1_s = $signed(YS_W'(h_eff - 1'b1));
  assign nx = (nx_s < 0) ? '0 : (nx_s > wm1_s) ? wm1_s[jbdf_pkg::X_W-1:0] : nx_s[jbdf_pkg::X_W-1:0];
  assign ny = (ny_s < 0) ? '0 : (ny_s > hm1_s) ? hm1_s[jbdf_pkg::Y_W-1:0] : ny_s[jbdf_pkg::Y_W-1:0];
  assign adx = (dx < 0) ? jbdf_pkg::RAD_W'(-dx) : jbdf_pkg::RAD_W'(dx);
  assign ady = (dy < 0) ? jbdf_pkg::RAD_W'(-dy) : jbdf_pkg::RAD_W'(dy);

  assign mem_addr = (state == S_WINDOW) ? {ny, nx} : {cy, cx};
  assign mem_we   = (state == S_LUMA_FIX) && (lrem < jbdf_pkg::LSUM_W'(255));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= {luma_sat, cdepth_in};
    end
    mem_rdata <= mem[mem_addr];
  end

  assign pipe_busy = v1 || v2 || v3 || v4 || v5;
  assign div_numer = jbdf_pkg::NUM_W'(dsum) + jbdf_pkg::NUM_W'(wsum >> 1);
  assign div_start = (state == S_DRAIN) && !pipe_busy && (wsum != '0);

  // Sequencer and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept && !out_of_frame) begin
            cx        <= pixel_x;
            cy        <= pixel_y;
            cr        <= red;
            cg        <= green;
            cb        <= blue;
            cdepth_in <= raw_depth;
            state     <= (command == jbdf_pkg::CMD_FILTER) ? S_CENTRE : S_LUMA_MUL;
          end
        end
        S_LUMA_MUL: begin
          lsum  <= jbdf_pkg::LSUM_W'(cr) * jbdf_pkg::LSUM_W'(red_weight)
                 + jbdf_pkg::LSUM_W'(cg) * jbdf_pkg::LSUM_W'(green_weight)
                 + jbdf_pkg::LSUM_W'(cb) * jbdf_pkg::LSUM_W'(blue_weight)
                 + jbdf_pkg::LSUM_W'(127);
          state <= S_LUMA_EST;
        end
        S_LUMA_EST: begin
          lq    <= jbdf_pkg::LQ_W'((jbdf_pkg::LPROD_W'(lsum) * jbdf_pkg::LPROD_W'(jbdf_pkg::INV255))
                                   >> jbdf_pkg::INV255_SH);
          state <= S_LUMA_FIX;
        end
        S_LUMA_FIX: begin
          if (lrem >= jbdf_pkg::LSUM_W'(255)) begin
            lq <= lq + 1'b1;
          end else begin
            state <= S_IDLE;
          end
        end
        S_CENTRE: begin
          state <= S_CAPTURE;
        end
        S_CAPTURE: begin
          c_luma  <= mem_rdata[jbdf_pkg::LUMA_W+jbdf_pkg::DEPTH_W-1:jbdf_pkg::DEPTH_W];
          c_depth <= mem_rdata[jbdf_pkg::DEPTH_W-1:0];
          dx      <= r_neg;
          dy      <= r_neg;
          state   <= S_WINDOW;
        end
        S_WINDOW: begin
          if (dx == r_pos) begin
            dx <= r_neg;
            dy <= dy + 1'b1;
            if (dy == r_pos) begin
              state <= S_DRAIN;
            end
          end else begin
            dx <= dx + 1'b1;
          end
        end
        S_DRAIN: begin
          if (!pipe_busy) begin
            if (wsum == '0) begin
              refined_depth <= c_depth;
              used_centre   <= 1'b1;
              out_x         <= cx;
              out_y         <= cy;
              result_valid  <= 1'b1;
              state         <= S_IDLE;
            end else begin
              state <= S_DIVIDE;
            end
          end
        end
        S_DIVIDE: begin
          if (div_done) begin
            refined_depth <= (div_quot[jbdf_pkg::NUM_W-1:16] != '0) ? 16'hFFFF : div_quot[15:0];
            used_centre   <= 1'b0;
            out_x         <= cx;
            out_y         <= cy;
            result_valid  <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v1 <= (state == S_WINDOW);
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  // The memory word for a neighbour arrives in the same cycle as stage one.
  assign dl = (mem_rdata[31:16] > c_luma) ? mem_rdata[31:16] - c_luma : c_luma - mem_rdata[31:16];
  assign dl_sq  = dl * dl;
  assign e_full = 33'(spatial_coeff) * 33'(p2_d2) + 33'(range_coeff) * 33'(p2_dl2);
  assign wt_next = (p3_e[15:8] >= 8'd17) ? '0 : (jbdf_pkg::FRAC_TABLE[p3_e[7:0]] >> p3_e[12:8]);

  always_ff @(posedge clk) begin
    p1_d2    <= jbdf_pkg::D2_W'(adx) * jbdf_pkg::D2_W'(adx)
              + jbdf_pkg::D2_W'(ady) * jbdf_pkg::D2_W'(ady);
    p2_d2    <= p1_d2;
    p2_dl2   <= dl_sq[2*jbdf_pkg::LUMA_W-1:jbdf_pkg::LUMA_W];
    p2_depth <= mem_rdata[jbdf_pkg::DEPTH_W-1:0];
    p3_e     <= (e_full > 33'd65535) ? 16'hFFFF : e_full[15:0];
    p3_depth <= p2_depth;
    p4_wt    <= wt_next;
    p4_depth <= p3_depth;
    p5_wt    <= p4_wt;
    p5_prod  <= p4_wt * p4_depth;
  end

  always_ff @(posedge clk) begin
    if (state == S_CAPTURE) begin
      wsum <= '0;
      dsum <= '0;
    end else if (v5) begin
      wsum <= wsum + jbdf_pkg::WSUM_W'(p5_wt);
      dsum <= dsum + jbdf_pkg::DSUM_W'(p5_prod);
    end
  end

  jbdf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (div_numer),
    .denom (wsum),
    .done  (div_done),
    .quot  (div_quot)
  );

`ifndef SYNTH
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ($past(state) == S_DRAIN || $past(state) == S_DIVIDE))
    else $error("result strobe outside drain or divide");
  a_pipe_when_busy: assert property (@(posedge clk) disable iff (rst)
    pipe_busy |-> busy)
    else $error("weighting pipeline active while idle");
  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIVIDE)
    else $error("divider finished outside divide state");
  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("two result strobes in a row");
`endif

endmodule
